FILE: src/evpi_pkg.sv
// Shared types, widths and constants of the encoder velocity PI drive.
package evpi_pkg;

    // Field and state widths.
    localparam int DUTY_BITS     = 13;
    localparam int SETPOINT_BITS = 12;
    localparam int COUNT_BITS    = 16;
    localparam int POWER_W       = DUTY_BITS + 1;
    localparam int ERR_W         = 21;
    localparam int SUM_W         = 32;
    localparam int GAIN_W        = 16;

    // Serial multiplier: a signed multiplicand times an unsigned gain.
    localparam int MCAND_W   = SUM_W + 1;
    localparam int PROD_W    = MCAND_W + GAIN_W;
    localparam int MUL_CNT_W = $clog2(GAIN_W);

    // Tick arithmetic widths.
    localparam int TGT_SHIFT = 8;
    localparam int TGT_W     = SETPOINT_BITS + GAIN_W - TGT_SHIFT;
    localparam int MEAS_W    = COUNT_BITS + GAIN_W + 1;
    localparam int DIFF_W    = MEAS_W + 1;
    localparam int Q_SHIFT   = 16;
    localparam int CTL_W     = PROD_W - Q_SHIFT;
    localparam int POW_SUM_W = CTL_W + 2;

    // Interface widths and field positions.
    localparam int IN_SETP_LSB  = 3;
    localparam int IN_DATA_W    = ((IN_SETP_LSB + SETPOINT_BITS + 7) / 8) * 8;
    localparam int OUT_DUTY_LSB = POWER_W;
    localparam int OUT_REV_BIT  = OUT_DUTY_LSB + DUTY_BITS;
    localparam int OUT_FWD_BIT  = OUT_REV_BIT + 1;
    localparam int OUT_ERR_LSB  = OUT_FWD_BIT + 1;
    localparam int OUT_DATA_W   = ((OUT_ERR_LSB + ERR_W + 7) / 8) * 8;
    localparam int CFG_IDX_W    = 2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETP = 2'd3;

    // Register reset values.
    localparam logic [GAIN_W-1:0] KP_RESET   = 16'd2560;
    localparam logic [GAIN_W-1:0] KI_RESET   = 16'd128;
    localparam logic [GAIN_W-1:0] VEL_RESET  = 16'd64;
    localparam logic [GAIN_W-1:0] SETP_RESET = 16'd8002;

    // Saturation limits.
    localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam logic signed [ERR_W-1:0]      ERR_MAX   = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0]      ERR_MIN   = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]      SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]      SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [POW_SUM_W-1:0]  POW_MAX   =
        POW_SUM_W'((2 ** DUTY_BITS) - 1);
    localparam logic signed [POW_SUM_W-1:0]  POW_MIN   = -POW_MAX;

    // Gain and scale registers as one bundle.
    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] vel_scale;
        logic [GAIN_W-1:0] setp_scale;
    } t_cfg;

    // Multiply request to the serial multiplier.
    typedef struct packed {
        logic                      start;
        logic signed [MCAND_W-1:0] mcand;
        logic [GAIN_W-1:0]         mplier;
    } t_mul_req;

    // Tick request to the control core.
    typedef struct packed {
        logic                     start;
        logic [SETPOINT_BITS-1:0] code;
    } t_tick_req;

    // Status back from the control core.
    typedef struct packed {
        logic done;
    } t_tick_stat;

endpackage

FILE: src/encoder_velocity_pi_motor_drive_top.sv
// Top level of the encoder velocity PI drive: handshakes, encoder counter, registers.
//
// Input channel (s_axis): each request is either an encoder edge event or a
// sample tick, told apart by tuser. An edge moves the saturating edge counter;
// a tick scales the set-point and the count to speed, runs the PI update on the
// power level and clears the count.
// Output channel (m_axis): every request yields exactly one result holding the
// signed power, the duty magnitude, both bridge direction bits and the speed
// error of the latest tick; tuser marks results that follow a tick.
// Configuration: a plain write port sets the two gains and two scales; the user
// must write it only while the block is idle, the block itself does not enforce this.
// Flow: an edge event goes to the output register once that register is free;
// a tick first runs through the core, where four products pass one bit-serial
// multiplier and the error, the integral and the power are saturated on the way.
// One request is in work at a time, so a new request is taken only once the
// previous result has been loaded into the output register.
// Reset clears the counter, the integral, the power and the error, and loads
// the register defaults. When the receiver stalls, the finished result waits in
// the output register while the next request is still taken and worked on; that
// request's result then waits until the register is free.
module encoder_velocity_pi_motor_drive_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [0] edge_on_b, [1] level_a, [2] level_b, [14:3] setpoint_code, [15] zero
    input  logic [evpi_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // [0] command
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [13:0] drive_power, [26:14] duty, [27] drive_in1, [28] drive_in2,
    // [49:29] speed_error, [55:50] zero
    output logic [evpi_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // [0] tick_done
    output logic                                o_m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [evpi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [evpi_pkg::GAIN_W-1:0]         i_cfg_wdata
);

    evpi_pkg::t_cfg                              r_cfg;
    logic signed [evpi_pkg::COUNT_BITS-1:0]      r_count;
    logic                                        r_busy;
    logic                                        r_work_done;
    logic                                        r_is_tick;
    logic                                        r_out_valid;
    logic [evpi_pkg::OUT_DATA_W-1:0]             r_out_data;
    logic                                        r_out_user;

    logic                                        accept;
    logic                                        load_out;
    logic                                        edge_up;
    logic signed [evpi_pkg::COUNT_BITS-1:0]      n_count;
    evpi_pkg::t_tick_req                         tick_req;
    evpi_pkg::t_tick_stat                        tick_stat;
    logic signed [evpi_pkg::POWER_W-1:0]         power;
    logic signed [evpi_pkg::ERR_W-1:0]           last_error;
    logic [evpi_pkg::POWER_W-1:0]                power_abs;
    logic [evpi_pkg::OUT_DATA_W-1:0]             n_out_data;

    // A new request is taken once the previous one has reached the output register.
    assign o_s_axis_tready = !r_busy;
    assign accept          = i_s_axis_tvalid && !r_busy;
    assign load_out        = r_busy && r_work_done && (!r_out_valid || i_m_axis_tready);

    assign tick_req.start = accept && i_s_axis_tuser;
    assign tick_req.code  = i_s_axis_tdata[evpi_pkg::IN_SETP_LSB +: evpi_pkg::SETPOINT_BITS];

    evpi_pi_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (tick_req),
        .i_cfg        (r_cfg),
        .i_edge_count (r_count),
        .o_stat       (tick_stat),
        .o_power      (power),
        .o_last_error (last_error)
    );

    // Quadrature decode: an edge on A counts up when both levels agree, an edge
    // on B the other way round. The count sticks at its signed limits.
    always_comb begin
        edge_up = (i_s_axis_tdata[1] == i_s_axis_tdata[2]) ^ i_s_axis_tdata[0];
        n_count = r_count;
        if (edge_up) begin
            if (r_count != evpi_pkg::COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (r_count != evpi_pkg::COUNT_MIN) begin
                n_count = r_count - 1'b1;
            end
        end
    end

    // Result assembled from the held drive state.
    always_comb begin
        power_abs  = power[evpi_pkg::POWER_W-1] ? -power : power;
        n_out_data = '0;
        n_out_data[evpi_pkg::POWER_W-1:0] = power;
        n_out_data[evpi_pkg::OUT_DUTY_LSB +: evpi_pkg::DUTY_BITS] =
            power_abs[evpi_pkg::DUTY_BITS-1:0];
        n_out_data[evpi_pkg::OUT_REV_BIT] = power[evpi_pkg::POWER_W-1];
        n_out_data[evpi_pkg::OUT_FWD_BIT] = !power[evpi_pkg::POWER_W-1] && (|power);
        n_out_data[evpi_pkg::OUT_ERR_LSB +: evpi_pkg::ERR_W] = last_error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp         <= evpi_pkg::KP_RESET;
            r_cfg.ki         <= evpi_pkg::KI_RESET;
            r_cfg.vel_scale  <= evpi_pkg::VEL_RESET;
            r_cfg.setp_scale <= evpi_pkg::SETP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                evpi_pkg::CFG_KP:   r_cfg.kp         <= i_cfg_wdata;
                evpi_pkg::CFG_KI:   r_cfg.ki         <= i_cfg_wdata;
                evpi_pkg::CFG_VEL:  r_cfg.vel_scale  <= i_cfg_wdata;
                evpi_pkg::CFG_SETP: r_cfg.setp_scale <= i_cfg_wdata;
                default:            r_cfg            <= r_cfg;
            endcase
        end
    end

    // Request tracking, edge counter and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_work_done <= 1'b0;
            r_is_tick   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy      <= 1'b1;
                r_is_tick   <= i_s_axis_tuser;
                r_work_done <= !i_s_axis_tuser;
                if (!i_s_axis_tuser) begin
                    r_count <= n_count;
                end
            end else if (load_out) begin
                r_busy      <= 1'b0;
                r_work_done <= 1'b0;
            end else if (tick_stat.done) begin
                r_work_done <= 1'b1;
                r_count     <= '0;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= n_out_data;
            r_out_user <= r_is_tick;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

FILE: src/evpi_serial_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand times unsigned gain.
module evpi_serial_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  evpi_pkg::t_mul_req                    i_req,
    output logic                                  o_done,
    output logic signed [evpi_pkg::PROD_W-1:0]    o_prod
);

    logic                                  r_run;
    logic                                  r_done;
    logic [evpi_pkg::MUL_CNT_W-1:0]        r_cnt;
    logic signed [evpi_pkg::MCAND_W-1:0]   r_mcand;
    logic signed [evpi_pkg::MCAND_W:0]     r_hi;
    logic [evpi_pkg::GAIN_W-1:0]           r_lo;
    logic signed [evpi_pkg::MCAND_W:0]     n_sum;

    // One multiplier bit per cycle; the partial product shifts right.
    always_comb begin
        n_sum = r_hi;
        if (r_lo[0]) begin
            n_sum = r_hi + {r_mcand[evpi_pkg::MCAND_W-1], r_mcand};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == evpi_pkg::MUL_CNT_W'(evpi_pkg::GAIN_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand <= i_req.mcand;
            r_hi    <= '0;
            r_lo    <= i_req.mplier;
        end else if (r_run) begin
            r_hi <= {n_sum[evpi_pkg::MCAND_W], n_sum[evpi_pkg::MCAND_W:1]};
            r_lo <= {n_sum[0], r_lo[evpi_pkg::GAIN_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[evpi_pkg::MCAND_W-1:0], r_lo};

endmodule

FILE: src/evpi_pi_core.sv
// Tick sequencer: speed scaling, error, integral and power update.
module evpi_pi_core (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  evpi_pkg::t_tick_req                      i_req,
    input  evpi_pkg::t_cfg                           i_cfg,
    input  logic signed [evpi_pkg::COUNT_BITS-1:0]   i_edge_count,
    output evpi_pkg::t_tick_stat                     o_stat,
    output logic signed [evpi_pkg::POWER_W-1:0]      o_power,
    output logic signed [evpi_pkg::ERR_W-1:0]        o_last_error
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TGT   = 3'd1;
    localparam logic [2:0] ST_MEAS  = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_KP    = 3'd4;
    localparam logic [2:0] ST_KI    = 3'd5;
    localparam logic [2:0] ST_TRUNC = 3'd6;
    localparam logic [2:0] ST_POW   = 3'd7;

    logic [2:0]                                 r_state;
    logic                                       r_done;
    logic [evpi_pkg::TGT_W-1:0]                 r_target;
    logic signed [evpi_pkg::ERR_W-1:0]          r_err;
    logic signed [evpi_pkg::SUM_W-1:0]          r_sum;
    logic signed [evpi_pkg::PROD_W-1:0]         r_acc;
    logic signed [evpi_pkg::CTL_W-1:0]          r_ctl;
    logic signed [evpi_pkg::POWER_W-1:0]        r_power;

    evpi_pkg::t_mul_req                         mul_req;
    logic                                       mul_done;
    logic signed [evpi_pkg::PROD_W-1:0]         mul_prod;

    logic signed [evpi_pkg::DIFF_W-1:0]         n_diff;
    logic signed [evpi_pkg::ERR_W-1:0]          n_err;
    logic signed [evpi_pkg::SUM_W:0]            n_sum_ext;
    logic signed [evpi_pkg::SUM_W-1:0]          n_sum;
    logic signed [evpi_pkg::PROD_W-1:0]         n_biased;
    logic signed [evpi_pkg::POW_SUM_W-1:0]      n_pow_ext;
    logic signed [evpi_pkg::POWER_W-1:0]        n_power;

    evpi_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Operands for each multiplication of the tick.
    always_comb begin
        mul_req = '0;
        case (r_state)
            ST_IDLE: begin
                mul_req.start  = i_req.start;
                mul_req.mcand  = {{(evpi_pkg::MCAND_W - evpi_pkg::SETPOINT_BITS){1'b0}},
                                  i_req.code};
                mul_req.mplier = i_cfg.setp_scale;
            end
            ST_TGT: begin
                mul_req.start  = mul_done;
                mul_req.mcand  = {{(evpi_pkg::MCAND_W - evpi_pkg::COUNT_BITS)
                                   {i_edge_count[evpi_pkg::COUNT_BITS-1]}}, i_edge_count};
                mul_req.mplier = i_cfg.vel_scale;
            end
            ST_SUM: begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = {{(evpi_pkg::MCAND_W - evpi_pkg::ERR_W)
                                   {r_err[evpi_pkg::ERR_W-1]}}, r_err};
                mul_req.mplier = i_cfg.kp;
            end
            ST_KP: begin
                mul_req.start  = mul_done;
                mul_req.mcand  = {r_sum[evpi_pkg::SUM_W-1], r_sum};
                mul_req.mplier = i_cfg.ki;
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    // Saturating arithmetic of the individual steps.
    always_comb begin
        n_diff = $signed({{(evpi_pkg::DIFF_W - evpi_pkg::TGT_W){1'b0}}, r_target})
               - $signed({mul_prod[evpi_pkg::MEAS_W-1], mul_prod[evpi_pkg::MEAS_W-1:0]});
        if ((&n_diff[evpi_pkg::DIFF_W-1:evpi_pkg::ERR_W-1])
            || !(|n_diff[evpi_pkg::DIFF_W-1:evpi_pkg::ERR_W-1])) begin
            n_err = n_diff[evpi_pkg::ERR_W-1:0];
        end else if (n_diff[evpi_pkg::DIFF_W-1]) begin
            n_err = evpi_pkg::ERR_MIN;
        end else begin
            n_err = evpi_pkg::ERR_MAX;
        end

        n_sum_ext = {r_sum[evpi_pkg::SUM_W-1], r_sum}
                  + {{(evpi_pkg::SUM_W + 1 - evpi_pkg::ERR_W){r_err[evpi_pkg::ERR_W-1]}},
                     r_err};
        if (n_sum_ext[evpi_pkg::SUM_W] == n_sum_ext[evpi_pkg::SUM_W-1]) begin
            n_sum = n_sum_ext[evpi_pkg::SUM_W-1:0];
        end else if (n_sum_ext[evpi_pkg::SUM_W]) begin
            n_sum = evpi_pkg::SUM_MIN;
        end else begin
            n_sum = evpi_pkg::SUM_MAX;
        end

        // Adding all ones below the cut makes the shift round toward zero.
        n_biased = r_acc + $signed({{(evpi_pkg::PROD_W - evpi_pkg::Q_SHIFT){1'b0}},
                                    {evpi_pkg::Q_SHIFT{r_acc[evpi_pkg::PROD_W-1]}}});

        n_pow_ext = $signed({{(evpi_pkg::POW_SUM_W - evpi_pkg::POWER_W)
                              {r_power[evpi_pkg::POWER_W-1]}}, r_power})
                  + $signed({{(evpi_pkg::POW_SUM_W - evpi_pkg::CTL_W)
                              {r_ctl[evpi_pkg::CTL_W-1]}}, r_ctl});
        if (n_pow_ext > evpi_pkg::POW_MAX) begin
            n_power = evpi_pkg::POW_MAX[evpi_pkg::POWER_W-1:0];
        end else if (n_pow_ext < evpi_pkg::POW_MIN) begin
            n_power = evpi_pkg::POW_MIN[evpi_pkg::POWER_W-1:0];
        end else begin
            n_power = n_pow_ext[evpi_pkg::POWER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_err   <= '0;
            r_sum   <= '0;
            r_power <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_req.start) begin
                        r_state <= ST_TGT;
                    end
                end
                ST_TGT: begin
                    if (mul_done) begin
                        r_state <= ST_MEAS;
                    end
                end
                ST_MEAS: begin
                    if (mul_done) begin
                        r_err   <= n_err;
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_sum   <= n_sum;
                    r_state <= ST_KP;
                end
                ST_KP: begin
                    if (mul_done) begin
                        r_state <= ST_KI;
                    end
                end
                ST_KI: begin
                    if (mul_done) begin
                        r_state <= ST_TRUNC;
                    end
                end
                ST_TRUNC: begin
                    r_state <= ST_POW;
                end
                ST_POW: begin
                    r_power <= n_power;
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Data registers along the tick; they need no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_TGT && mul_done) begin
            r_target <= mul_prod[evpi_pkg::TGT_SHIFT +: evpi_pkg::TGT_W];
        end
        if (r_state == ST_KP && mul_done) begin
            r_acc <= mul_prod;
        end
        if (r_state == ST_KI && mul_done) begin
            r_acc <= r_acc + mul_prod;
        end
        if (r_state == ST_TRUNC) begin
            r_ctl <= n_biased[evpi_pkg::PROD_W-1:evpi_pkg::Q_SHIFT];
        end
    end

    assign o_stat.done  = r_done;
    assign o_power      = r_power;
    assign o_last_error = r_err;

endmodule

FILE: verif/evpi_drive_checker.sv
// Checker of the encoder velocity PI drive: predicts every result from the requests and compares.
`timescale 1ns / 100ps
module evpi_drive_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    input  logic                               i_s_axis_tready,
    // [0] edge_on_b, [1] level_a, [2] level_b, [14:3] setpoint_code, [15] zero
    input  logic [evpi_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [0] command
    input  logic                               i_s_axis_tuser,
    input  logic                               i_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [13:0] drive_power, [26:14] duty, [27] drive_in1, [28] drive_in2,
    // [49:29] speed_error, [55:50] zero
    input  logic [evpi_pkg::OUT_DATA_W-1:0]    i_m_axis_tdata,
    // [0] tick_done
    input  logic                               i_m_axis_tuser,
    input  logic                               i_cfg_we,
    input  logic [evpi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [evpi_pkg::GAIN_W-1:0]        i_cfg_wdata,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import evpi_pkg::*;

    localparam int EDGE_B_BIT = 0;
    localparam int LVL_A_BIT  = 1;
    localparam int LVL_B_BIT  = 2;
    localparam int SETP_LSB   = 3;

    localparam int DUTY_LSB = POWER_W;
    localparam int REV_BIT  = DUTY_LSB + DUTY_BITS;
    localparam int FWD_BIT  = REV_BIT + 1;
    localparam int ERR_LSB  = FWD_BIT + 1;
    localparam int PAD_LSB  = ERR_LSB + ERR_W;

    typedef struct packed {
        logic signed [POWER_W-1:0] power;
        logic [DUTY_BITS-1:0]      duty;
        logic                      reverse;
        logic                      forward;
        logic signed [ERR_W-1:0]   speed_err;
        logic                      tick;
    } t_drive_state;

    t_cfg                         gains;
    logic signed [COUNT_BITS-1:0] edge_tally;
    logic signed [SUM_W-1:0]      err_integral;
    logic signed [POWER_W-1:0]    power_now;
    logic signed [ERR_W-1:0]      err_latest;

    t_drive_state drive_expected[$];
    t_drive_state seen;
    t_drive_state wanted;
    int           result_no  = 0;
    int           fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic longint saturate(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", result_no, what);
        fail_total++;
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] got,
                                 input logic signed [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // Moves the drive state on by one request and gives the result that it should produce.
    task automatic advance_drive(input logic is_tick, input logic [IN_DATA_W-1:0] data,
                                 output t_drive_state res);
        longint target;
        longint measured;
        longint err;
        longint acc;
        longint corr;
        longint mag;
        logic   same_level;
        logic   count_up;
        if (!is_tick) begin
            same_level = (data[LVL_A_BIT] == data[LVL_B_BIT]);
            count_up   = data[EDGE_B_BIT] ? !same_level : same_level;
            edge_tally = COUNT_BITS'(saturate(longint'(edge_tally) + (count_up ? 1 : -1),
                                              longint'(COUNT_MIN), longint'(COUNT_MAX)));
        end else begin
            target   = longint'(data[SETP_LSB +: SETPOINT_BITS]) *
                       longint'(gains.setp_scale) >>> TGT_SHIFT;
            measured = longint'(edge_tally) * longint'(gains.vel_scale);
            err      = saturate(target - measured, longint'(ERR_MIN), longint'(ERR_MAX));
            edge_tally   = '0;
            err_integral = SUM_W'(saturate(longint'(err_integral) + err,
                                           longint'(SUM_MIN), longint'(SUM_MAX)));
            acc  = longint'(gains.kp) * err + longint'(gains.ki) * longint'(err_integral);
            // The correction is truncated towards zero, not floored.
            corr = (acc < 0) ? -((-acc) >>> Q_SHIFT) : (acc >>> Q_SHIFT);
            power_now  = POWER_W'(saturate(longint'(power_now) + corr,
                                           longint'(POW_MIN), longint'(POW_MAX)));
            err_latest = ERR_W'(err);
        end
        mag           = (power_now < 0) ? -longint'(power_now) : longint'(power_now);
        res.power     = power_now;
        res.duty      = DUTY_BITS'(saturate(mag, 0, longint'(POW_MAX)));
        res.reverse   = (power_now < 0);
        res.forward   = (power_now > 0);
        res.speed_err = err_latest;
        res.tick      = is_tick;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gains        = '{kp: KP_RESET, ki: KI_RESET, vel_scale: VEL_RESET,
                             setp_scale: SETP_RESET};
            edge_tally   = '0;
            err_integral = '0;
            power_now    = '0;
            err_latest   = '0;
            drive_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KP:   gains.kp         = i_cfg_wdata;
                    CFG_KI:   gains.ki         = i_cfg_wdata;
                    CFG_VEL:  gains.vel_scale  = i_cfg_wdata;
                    CFG_SETP: gains.setp_scale = i_cfg_wdata;
                    default:  ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                seen.power     = i_m_axis_tdata[0 +: POWER_W];
                seen.duty      = i_m_axis_tdata[DUTY_LSB +: DUTY_BITS];
                seen.reverse   = i_m_axis_tdata[REV_BIT];
                seen.forward   = i_m_axis_tdata[FWD_BIT];
                seen.speed_err = i_m_axis_tdata[ERR_LSB +: ERR_W];
                seen.tick      = i_m_axis_tuser;
                if (drive_expected.size() == 0) begin
                    report_mismatch("result arrived with no request outstanding");
                end else begin
                    wanted = drive_expected.pop_front();
                    compare_field("drive_power", seen.power, wanted.power);
                    compare_field("duty", seen.duty, wanted.duty);
                    compare_field("drive_in1", seen.reverse, wanted.reverse);
                    compare_field("drive_in2", seen.forward, wanted.forward);
                    compare_field("speed_error", seen.speed_err, wanted.speed_err);
                    compare_field("tick_done", seen.tick, wanted.tick);
                    compare_field("padding", i_m_axis_tdata[OUT_DATA_W-1:PAD_LSB], 0);
                end
                result_no++;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                advance_drive(i_s_axis_tuser, i_s_axis_tdata, wanted);
                drive_expected.push_back(wanted);
            end
        end
        o_pending <= drive_expected.size();
    end

endmodule

FILE: verif/encoder_velocity_pi_motor_drive_top_tb.sv
// Testbench top of the encoder velocity PI drive: request stimulus, handshake idling, verdict.
`timescale 1ns / 100ps
module encoder_velocity_pi_motor_drive_top_tb;
    import evpi_pkg::*;

    // Command codes carried in the request tuser.
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // A tick, a receiver stall and a sender gap are all far shorter than STALL_LIMIT,
    // so a quiet spell that long can only mean the block has hung.
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_ITEMS   = 215;

    // Each tick of the last part follows a run of NEG_EDGES encoder events, which at full velocity scale
    // push the error past its limit: up edges before a zero set-point give the lower
    // limit, down edges before the largest set-point the upper one.
    localparam int NEG_TICKS  = 8;
    localparam int POS_TICKS  = 12;
    localparam int NEG_EDGES  = 17;
    // A short run whose count shows directly in the error.
    localparam int COUNT_RUN  = 60;

    logic                   i_clk;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // [0] edge_on_b, [1] level_a, [2] level_b, [14:3] setpoint_code, [15] zero
    logic [IN_DATA_W-1:0]   i_s_axis_tdata  = '0;
    // [0] command
    logic                   i_s_axis_tuser  = CMD_EDGE;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [13:0] drive_power, [26:14] duty, [27] drive_in1, [28] drive_in2,
    // [49:29] speed_error, [55:50] zero
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;
    // [0] tick_done
    logic                   o_m_axis_tuser;
    logic                   i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index     = CFG_KP;
    logic [GAIN_W-1:0]      i_cfg_wdata     = '0;

    int   fail_count;
    int   pending;
    logic idle_enable   = 1'b1;
    int   stall_left    = 0;
    int   quiet_cycles  = 0;
    int   edge_total    = 0;
    int   tick_total    = 0;
    int   setting_total = 1;

    encoder_velocity_pi_motor_drive_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // The checker sees both channels and the register port exactly as the block does.
    evpi_drive_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: ready drops at random while idling is enabled, held low by stall_left, so
    // results back up into the output register at every stage of the block's work.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= $urandom_range(0, 9);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: any accepted request or result restarts the count.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT - 1) begin
            $display("Watchdog: nothing moved on either channel for %0d cycles.", STALL_LIMIT);
            $display("encoder_velocity_pi_motor_drive_top_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_request(logic on_b, logic lvl_a,
                                                          logic lvl_b,
                                                          logic [SETPOINT_BITS-1:0] code);
        return {1'b0, code, lvl_b, lvl_a, on_b};
    endfunction

    // Set-point codes favour the two ends of the range.
    function automatic logic [SETPOINT_BITS-1:0] random_code();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SETPOINT_BITS'($urandom_range(0, (2 ** SETPOINT_BITS) - 1));
        endcase
    endfunction

    // Offers one request and holds it until it is accepted. Valid stays high afterwards,
    // so back-to-back requests never see valid lowered and raised in the same step; it
    // only drops when a gap is chosen at the start of the next request or results are drained.
    task automatic send_request(input logic cmd, input logic [IN_DATA_W-1:0] data);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (cmd == CMD_TICK) tick_total++;
        else edge_total++;
    endtask

    // An edge event; the set-point field is ignored by the block but still toggled.
    task automatic send_edge(input logic on_b, input logic lvl_a, input logic lvl_b);
        send_request(CMD_EDGE, pack_request(on_b, lvl_a, lvl_b, random_code()));
    endtask

    // A sample tick; the edge fields are ignored by the block but still toggled.
    task automatic send_tick(input logic [SETPOINT_BITS-1:0] code);
        send_request(CMD_TICK, pack_request(1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)), code));
    endtask

    // One edge that moves the count in the given direction, on a random channel and
    // with random levels. An edge on A counts up when the levels agree, an edge on B
    // counts up when they differ.
    task automatic send_motion(input logic count_up);
        logic on_b;
        logic lvl_a;
        logic agree;
        on_b  = 1'($urandom_range(0, 1));
        lvl_a = 1'($urandom_range(0, 1));
        agree = on_b ? !count_up : count_up;
        send_edge(on_b, lvl_a, agree ? lvl_a : !lvl_a);
    endtask

    // Stops offering requests and waits until every outstanding result has been taken,
    // then a few cycles more so the block is certainly idle.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes all four registers back to back while the block is idle. The write enable
    // stays high across the four writes and is lowered once at the end.
    task automatic apply_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                  input logic [GAIN_W-1:0] vel, input logic [GAIN_W-1:0] setp);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_KP;
        i_cfg_wdata <= kp;
        @(posedge i_clk);
        i_cfg_index <= CFG_KI;
        i_cfg_wdata <= ki;
        @(posedge i_clk);
        i_cfg_index <= CFG_VEL;
        i_cfg_wdata <= vel;
        @(posedge i_clk);
        i_cfg_index <= CFG_SETP;
        i_cfg_wdata <= setp;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        setting_total++;
    endtask

    // Mostly runs of edges in one direction closed by a tick, as a turning shaft gives;
    // the rest is noise with every field random.
    task automatic run_random_phase(input int n_items);
        int   sent;
        int   run_len;
        logic dir_up;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                run_len = $urandom_range(0, 24);
                dir_up  = 1'($urandom_range(0, 1));
                for (int k = 0; k < run_len; k++) begin
                    // An occasional reversal stands in for jitter at a standstill.
                    if ($urandom_range(0, 15) == 0) send_motion(!dir_up);
                    else send_motion(dir_up);
                end
                send_tick(random_code());
                sent += run_len + 1;
            end else begin
                send_request(1'($urandom_range(0, 1)), {1'b0, 15'($urandom())});
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. First every combination of channel and levels: on A the count
        // goes up when the levels agree, on B when they differ, so the eight cancel out.
        for (int k = 0; k < 8; k++) send_edge(k[2], k[1], k[0]);
        // Zero set-point with an empty count gives zero error and zero power (coast).
        send_tick('0);
        repeat (3) send_motion(1'b1);
        // Full-scale set-point twice, so the integral builds on itself.
        send_tick('1);
        send_tick('1);
        repeat (3) send_motion(1'b0);
        send_tick(SETPOINT_BITS'(2 ** (SETPOINT_BITS - 1)));

        // Random part, first at the reset values, then through the extremes and a few
        // random settings. Each change of settings waits for every result beforehand.
        run_random_phase(PHASE_ITEMS);
        apply_settings('1, '1, '1, '1);
        run_random_phase(PHASE_ITEMS);
        apply_settings('0, '0, '0, '0);
        run_random_phase(PHASE_ITEMS);
        apply_settings('1, '0, 16'd1, '1);
        run_random_phase(PHASE_ITEMS);
        apply_settings(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
        run_random_phase(PHASE_ITEMS);
        apply_settings(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 128)),
                       16'($urandom_range(0, 512)), 16'($urandom()));
        run_random_phase(PHASE_ITEMS);

        // Last part, with no idling on either side. Drive the error to its lower limit,
        // then to its upper limit; the power saturates at both ends on the way.
        idle_enable <= 1'b0;
        apply_settings(KP_RESET, KI_RESET, '1, '1);
        for (int k = 0; k < NEG_TICKS; k++) begin
            repeat (NEG_EDGES) send_motion(1'b1);
            send_tick('0);
        end
        for (int k = 0; k < POS_TICKS; k++) begin
            repeat (NEG_EDGES) send_motion(1'b0);
            send_tick('1);
        end

        // With a unit velocity scale and a zero set-point the error shows the negated count,
        // first after a run up, then after a run down.
        apply_settings(KP_RESET, KI_RESET, 16'd1, '0);
        repeat (COUNT_RUN) send_motion(1'b1);
        send_tick('0);
        repeat (COUNT_RUN) send_motion(1'b0);
        send_tick('0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d encoder edges and %0d sample ticks under %0d settings,",
                 edge_total, tick_total, setting_total);
        $display("reaching both limits of the speed error and of the power level.");
        if (fail_count == 0 && pending == 0) begin
            $display("encoder_velocity_pi_motor_drive_top_tb OK");
        end else begin
            $display("encoder_velocity_pi_motor_drive_top_tb NOT OK");
        end
        $finish;
    end

endmodule
